// ===== design/led_driver_frame_builder_assert.svh =====
// Assertion macros shared by the frame builder RTL.
// No dependencies; expects clk_i and rst_ni in the including module.
`ifndef LED_DRIVER_FRAME_BUILDER_ASSERT_SVH
`define LED_DRIVER_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication
`define LDFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ldfb_pkg.sv =====
// Package for the LED driver frame builder: item kinds, frame constants
// and the gamma table. No dependencies.
package ldfb_pkg;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [15:0] REG_WORD_RESET = 16'h0018;

  localparam logic [7:0] BYTE_FILL = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_STOP = 8'h80;

  localparam logic [4:0] HDR_FILL_LEN = 5'd16;
  localparam logic [4:0] HDR_LEN      = 5'd22;
  localparam logic [4:0] TRL_FILL_LEN = 5'd18;
  localparam logic [4:0] TRL_LEN      = 5'd19;
  localparam logic [4:0] GRP_LEN      = 5'd28;

  typedef logic [255:0][15:0] gamma_tab_t;

  // floor(65535 * (0.55*i/255)^1.8): largest v with v^5 * 5100^9 <= 65535^5 * (11i)^9
  function automatic gamma_tab_t gamma_table();
    gamma_tab_t  tab;
    logic [199:0] rhs;
    logic [199:0] lhs;
    logic [16:0]  lo;
    logic [16:0]  hi;
    logic [16:0]  mid;
    for (int i = 0; i < 256; i++) begin
      rhs = 200'd1;
      for (int k = 0; k < 5; k++) rhs = rhs * 200'd65535;
      for (int k = 0; k < 9; k++) rhs = rhs * 200'(11 * i);
      lo = 17'd0;
      hi = 17'd65535;
      for (int s = 0; s < 17; s++) begin
        if (lo < hi) begin
          mid = (lo + hi + 17'd1) >> 1;
          lhs = 200'(mid);
          for (int k = 0; k < 4; k++) lhs = lhs * 200'(mid);
          for (int k = 0; k < 9; k++) lhs = lhs * 200'd5100;
          if (lhs <= rhs) lo = mid;
          else hi = mid - 17'd1;
        end
      end
      tab[i] = lo[15:0];
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA_ROM = gamma_table();

endpackage

// ===== design/led_driver_frame_builder.sv =====
// LED driver frame builder: item stream in, frame byte stream out.
// Uses ldfb_pkg and led_driver_frame_builder_assert.svh.
//
// Input channel (valid/ready) takes one item per word: kind, red, green,
// blue. Output channel (valid/ready) gives one frame byte per word with
// run_last_o marking the last byte of an item. cfg_we_i/cfg_wdata_i write
// the driver register word sent in the header (reset value 0x0018).
// A byte sequencer issues one byte per cycle unless the output stalls:
// a start item gives 22 bytes, an end item 19, a completed group of four
// pixels 28, i.e. 7 per pixel. The sequencer is what sets the rate. Pixels
// that only get stored are taken in any cycle, also while a group is being
// sent, into the second bank of a two-bank pixel memory. Start, end and
// group-completing pixels are taken once the sequencer issues the last byte
// of the job before. The first byte of a job passes the sequencer state,
// memory read, gamma lookup and output registers on its way out. A stall on
// the output freezes the whole byte pipeline; nothing is lost. Reset empties
// the pipeline and the group; no clearing pass is needed.
module led_driver_frame_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o
);

  `include "led_driver_frame_builder_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HDR  = 4'b0010,
    ST_GRP  = 4'b0100,
    ST_TRL  = 4'b1000
  } seq_state_e;

  typedef struct packed {
    logic       gamma;
    logic [1:0] slot;
    logic [1:0] colour;
    logic       hi;
    logic [7:0] cbyte;
    logic       last;
  } ctrl_t;

  seq_state_e  state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic        job_bank_q;
  logic        wr_bank_q;
  logic [1:0]  pos_q;
  logic [15:0] reg_word_q;

  logic [23:0] pix_mem [8];
  logic [23:0] rd_q;
  ctrl_t       iss, c1_q, c2_q;
  logic        v1_q, v2_q;
  logic [15:0] gamma_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_valid_q;

  logic        en;
  logic        issue;
  logic        issue_last;
  logic        can_start;
  logic        accept;
  logic        is_pixel, is_start, is_end, grp_done, pix_wr, starter;
  logic [2:0]  off;
  logic [7:0]  sel;

  assign en         = !out_valid_q || out_ready_i;
  assign issue      = (state_q != ST_IDLE) && en;
  assign issue_last = issue && iss.last;
  assign can_start  = (state_q == ST_IDLE) || issue_last;

  assign is_pixel = kind_i == ldfb_pkg::KIND_PIXEL;
  assign is_start = kind_i == ldfb_pkg::KIND_START;
  assign is_end   = kind_i == ldfb_pkg::KIND_END;
  assign grp_done = is_pixel && (pos_q == 2'd3);
  assign starter  = is_start || is_end || grp_done;

  assign in_ready_o = !starter || can_start;
  assign accept     = in_valid_i && in_ready_o;
  assign pix_wr     = accept && is_pixel;

  // byte decode for the current step
  always_comb begin
    iss = '0;
    off = 3'd0;
    unique case (state_q)
      ST_HDR: begin
        iss.last = step_q == ldfb_pkg::HDR_LEN - 5'd1;
        priority if (step_q < ldfb_pkg::HDR_FILL_LEN) iss.cbyte = ldfb_pkg::BYTE_FILL;
        else if (step_q == 5'd18) iss.cbyte = reg_word_q[15:8];
        else if (step_q == 5'd19) iss.cbyte = reg_word_q[7:0];
        else iss.cbyte = ldfb_pkg::BYTE_ZERO;
      end
      ST_TRL: begin
        iss.last  = step_q == ldfb_pkg::TRL_LEN - 5'd1;
        iss.cbyte = iss.last ? ldfb_pkg::BYTE_STOP : ldfb_pkg::BYTE_FILL;
      end
      ST_GRP: begin
        iss.last  = step_q == ldfb_pkg::GRP_LEN - 5'd1;
        iss.cbyte = ldfb_pkg::BYTE_ZERO;
        iss.gamma = 1'b1;
        priority if (step_q < 5'd6) begin
          iss.slot = 2'd1;
          off      = step_q[2:0];
        end else if (step_q < 5'd12) begin
          iss.slot = 2'd0;
          off      = 3'(step_q - 5'd6);
        end else if (step_q < 5'd14) begin
          iss.gamma = 1'b0;
        end else if (step_q < 5'd20) begin
          iss.slot = 2'd3;
          off      = 3'(step_q - 5'd14);
        end else if (step_q < 5'd26) begin
          iss.slot = 2'd2;
          off      = 3'(step_q - 5'd20);
        end else begin
          iss.gamma = 1'b0;
        end
        iss.colour = off[2:1];
        iss.hi     = !off[0];
      end
      default: iss = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    if (accept && starter) begin
      step_d = 5'd0;
      priority if (is_start) state_d = ST_HDR;
      else if (is_end) state_d = ST_TRL;
      else state_d = ST_GRP;
    end else if (issue) begin
      if (iss.last) begin
        state_d = ST_IDLE;
      end else begin
        step_d = step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 5'd0;
      job_bank_q  <= 1'b0;
      wr_bank_q   <= 1'b0;
      pos_q       <= 2'd0;
      reg_word_q  <= ldfb_pkg::REG_WORD_RESET;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        reg_word_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (is_start || is_end || grp_done) begin
          pos_q <= 2'd0;
        end else if (is_pixel) begin
          pos_q <= pos_q + 2'd1;
        end
        if (grp_done) begin
          job_bank_q <= wr_bank_q;
          wr_bank_q  <= !wr_bank_q;
        end
      end
      if (en) begin
        v1_q        <= issue;
        v2_q        <= v1_q;
        out_valid_q <= v2_q;
      end
    end
  end

  // pixel memory: bank = group, slot = pixel position; the emitting group
  // reads one bank while new pixels fill the other
  always_ff @(posedge clk_i) begin
    if (pix_wr) begin
      pix_mem[{wr_bank_q, pos_q}] <= {red_i, green_i, blue_i};
    end
    if (en) begin
      rd_q <= pix_mem[{job_bank_q, iss.slot}];
      c1_q <= iss;
    end
  end

  always_comb begin
    unique case (c1_q.colour)
      2'd1:    sel = rd_q[15:8];
      2'd2:    sel = rd_q[23:16];
      default: sel = rd_q[7:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gamma_q <= ldfb_pkg::GAMMA_ROM[sel];
      c2_q    <= c1_q;
      if (c2_q.gamma) begin
        out_byte_q <= c2_q.hi ? gamma_q[15:8] : gamma_q[7:0];
      end else begin
        out_byte_q <= c2_q.cbyte;
      end
      out_last_q <= c2_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

  `LDFB_ASSERT_NOW(a_bank_split, (state_q == ST_GRP) && pix_wr,
    wr_bank_q != job_bank_q, "pixel store hit the bank being sent")
  `LDFB_ASSERT_NEXT(a_grp_start, accept && grp_done,
    (state_q == ST_GRP) && (step_q == 5'd0), "group did not start")
  `LDFB_ASSERT_NEXT(a_frame_reset, accept && (is_start || is_end),
    pos_q == 2'd0, "group position not cleared")
  `LDFB_ASSERT_NOW(a_step_range, state_q != ST_IDLE,
    step_q < ldfb_pkg::GRP_LEN, "step past job length")

endmodule
